// File: rtl/hdtb_pkg.sv
// ----------------------------------------------------------------------------
// hdtb_pkg
// Shared types and codes for the Huffman decode table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hdtb_pkg;

    localparam int LEN_BITS = 4;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW   = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;
    localparam logic [1:0] STATUS_ORDER      = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [LEN_BITS-1:0] code_length;
        logic [7:0]          symbol;
        logic [10:0]         lookup_bits;
    } request_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [LEN_BITS-1:0] out_length;
        logic [7:0]          out_symbol;
    } response_t;

endpackage

`default_nettype wire

// File: rtl/hdtb_ram.sv
// ----------------------------------------------------------------------------
// hdtb_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hdtb_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/huffman_decode_table_builder_unit.sv
// ----------------------------------------------------------------------------
// huffman_decode_table_builder_unit
// Builds a single-level canonical Huffman decode table in RAM and serves
// slot lookups from it.
// ----------------------------------------------------------------------------
// clear, finish, rejected add: result in the cycle after the transaction, 1 per cycle
// accepted add: 2^(INDEX_BITS-code_length) slot writes, one per cycle on the single
//   RAM write port, result in the cycle after the last write; lookup: RAM read, then result reg
// busy while filling or reading; the next transaction is taken in the result cycle
// reset clears fill pointer, error and control, sets previous length to 1; table contents
//   stay undefined until written, no clearing pass; results cannot be stalled
`default_nettype none

module huffman_decode_table_builder_unit #(
    parameter int INDEX_BITS  = 11,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire hdtb_pkg::request_t request,
    output logic                    busy,
    output logic                    done,
    output hdtb_pkg::response_t     response
);

    localparam int WORD_BITS = hdtb_pkg::LEN_BITS + SYMBOL_BITS;
    localparam int SLOTS     = 1 << INDEX_BITS;
    localparam logic [INDEX_BITS:0]   FULL_COUNT = {1'b1, {INDEX_BITS{1'b0}}};
    localparam logic [INDEX_BITS+1:0] SLOT_LIMIT = {2'b01, {INDEX_BITS{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FILL = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    logic [INDEX_BITS:0]               fill_ptr_reg, fill_ptr_next;
    logic [INDEX_BITS-1:0]             count_reg, count_next;
    logic [hdtb_pkg::LEN_BITS-1:0]     prev_len_reg, prev_len_next;
    logic [1:0]                        err_reg, err_next;
    logic [WORD_BITS-1:0]              word_reg, word_next;
    logic                              done_reg, done_next;
    hdtb_pkg::response_t               resp_reg, resp_next;

    logic                              accept;
    logic [hdtb_pkg::LEN_BITS-1:0]     len;
    logic                              len_ok;
    logic [hdtb_pkg::LEN_BITS-1:0]     shamt;
    logic [INDEX_BITS:0]               span;
    logic [INDEX_BITS+1:0]             fill_end;

    logic                              wr_en;
    logic                              rd_en;
    logic [INDEX_BITS-1:0]             rd_addr;
    logic [WORD_BITS-1:0]              rd_data;

    assign accept = start && (state_reg == ST_IDLE);
    assign len    = request.code_length;
    assign len_ok = (len != '0) && (len <= hdtb_pkg::LEN_BITS'(INDEX_BITS))
                    && (len >= prev_len_reg);
    assign shamt  = hdtb_pkg::LEN_BITS'(INDEX_BITS) - len;
    assign span   = (INDEX_BITS+1)'(1) << shamt;
    assign fill_end = {1'b0, fill_ptr_reg} + {1'b0, span};

    assign wr_en   = (state_reg == ST_FILL);
    assign rd_en   = accept && (request.cmd == hdtb_pkg::CMD_LOOKUP);
    assign rd_addr = INDEX_BITS'(request.lookup_bits);

    hdtb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_ptr_reg[INDEX_BITS-1:0]),
        .wr_data (word_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        fill_ptr_next = fill_ptr_reg;
        count_next    = count_reg;
        prev_len_next = prev_len_reg;
        err_next      = err_reg;
        word_next     = word_reg;
        done_next     = 1'b0;
        resp_next     = resp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    resp_next = '0;
                    unique case (hdtb_pkg::cmd_t'(request.cmd))
                        hdtb_pkg::CMD_CLEAR:
                        begin
                            fill_ptr_next    = '0;
                            prev_len_next    = hdtb_pkg::LEN_BITS'(1);
                            err_next         = hdtb_pkg::STATUS_OK;
                            resp_next.status = hdtb_pkg::STATUS_OK;
                            done_next        = 1'b1;
                        end
                        hdtb_pkg::CMD_ADD:
                        begin
                            if (err_reg != hdtb_pkg::STATUS_OK)
                            begin
                                resp_next.status = err_reg;
                                done_next        = 1'b1;
                            end
                            else if (!len_ok)
                            begin
                                err_next         = hdtb_pkg::STATUS_ORDER;
                                resp_next.status = hdtb_pkg::STATUS_ORDER;
                                done_next        = 1'b1;
                            end
                            else if (fill_end > SLOT_LIMIT)
                            begin
                                err_next         = hdtb_pkg::STATUS_OVERFLOW;
                                resp_next.status = hdtb_pkg::STATUS_OVERFLOW;
                                done_next        = 1'b1;
                            end
                            else
                            begin
                                prev_len_next = len;
                                count_next    = INDEX_BITS'(span - 1'b1);
                                word_next     = {len, SYMBOL_BITS'(request.symbol)};
                                state_next    = ST_FILL;
                            end
                        end
                        hdtb_pkg::CMD_FINISH:
                        begin
                            if (err_reg != hdtb_pkg::STATUS_OK)
                            begin
                                resp_next.status = err_reg;
                            end
                            else if (fill_ptr_reg != FULL_COUNT)
                            begin
                                resp_next.status = hdtb_pkg::STATUS_INCOMPLETE;
                            end
                            else
                            begin
                                resp_next.status = hdtb_pkg::STATUS_OK;
                            end
                            done_next = 1'b1;
                        end
                        hdtb_pkg::CMD_LOOKUP:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                // one slot per cycle from the fill pointer
                fill_ptr_next = fill_ptr_reg + 1'b1;
                count_next    = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    resp_next  = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                resp_next.status     = err_reg;
                resp_next.out_length = rd_data[WORD_BITS-1:SYMBOL_BITS];
                resp_next.out_symbol = 8'(rd_data[SYMBOL_BITS-1:0]);
                done_next            = 1'b1;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_ptr_reg <= '0;
            count_reg    <= '0;
            prev_len_reg <= hdtb_pkg::LEN_BITS'(1);
            err_reg      <= hdtb_pkg::STATUS_OK;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_ptr_reg <= fill_ptr_next;
            count_reg    <= count_next;
            prev_len_reg <= prev_len_next;
            err_reg      <= err_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        resp_reg <= resp_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign response = resp_reg;

endmodule

`default_nettype wire
